// ===== rtl/i2c_mts_pkg.sv =====
// ============================================================================
// i2c_mts_pkg
// Shared types and codes for the i2c master transfer sequencer.
// ============================================================================
package i2c_mts_pkg;

    localparam int ADDR_W   = 7;
    localparam int BYTE_W   = 8;
    localparam int LIMIT_W  = 24;
    localparam int TOTAL_W  = 16;
    localparam int FRAME_W  = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0]  FRAMED_MAX_LEN     = 8'd250;
    localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RESET  = 24'd4096;
    localparam logic [LIMIT_W-1:0] LONG_LIMIT_RESET   = 24'd65536;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_ADDRESS = 2'd0,
        CFG_SHORT_LIMIT = 2'd1,
        CFG_LONG_LIMIT  = 2'd2
    } cfg_idx_t;

    // request codes
    typedef enum logic [2:0] {
        REQ_TICK    = 3'd0,
        REQ_WRITE   = 3'd1,
        REQ_FRAMED  = 3'd2,
        REQ_READ    = 3'd3,
        REQ_PAYLOAD = 3'd4
    } req_code_t;

    // controller actions
    typedef enum logic [3:0] {
        ACT_NONE         = 4'd0,
        ACT_START        = 4'd1,
        ACT_ADDR_WRITE   = 4'd2,
        ACT_ADDR_READ    = 4'd3,
        ACT_SEND_BYTE    = 4'd4,
        ACT_ACK_ON       = 4'd5,
        ACT_ACK_OFF      = 4'd6,
        ACT_ACK_OFF_STOP = 4'd7,
        ACT_STOP         = 4'd8,
        ACT_IRQ_ON       = 4'd9
    } action_t;

    typedef enum logic [8:0] {
        PH_IDLE     = 9'b000000001,
        PH_BUS_PRE  = 9'b000000010,
        PH_START    = 9'b000000100,
        PH_ADDR     = 9'b000001000,
        PH_WANT     = 9'b000010000,
        PH_TXING    = 9'b000100000,
        PH_TXD      = 9'b001000000,
        PH_RX       = 9'b010000000,
        PH_BUS_POST = 9'b100000000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PLAIN  = 2'd0,
        KIND_FRAMED = 2'd1,
        KIND_READ   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  own_address;
        logic [LIMIT_W-1:0] short_wait_limit;
        logic [LIMIT_W-1:0] long_wait_limit;
    } cfg_t;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [ADDR_W-1:0] target_addr;
        logic [BYTE_W-1:0] xfer_length;
        logic [BYTE_W-1:0] payload_byte;
        logic              bus_busy;
        logic              start_done;
        logic              addr_done;
        logic              byte_transmitting;
        logic              byte_transmitted;
        logic              byte_received;
        logic [BYTE_W-1:0] rx_data;
    } req_t;

    typedef struct packed {
        action_t            action;
        logic [BYTE_W-1:0]  out_byte;
        logic               need_byte;
        logic               read_valid;
        logic [BYTE_W-1:0]  read_byte;
        logic               done_res;
        logic               failed;
        logic [TOTAL_W-1:0] error_total;
    } res_t;

    typedef struct packed {
        phase_t             phase;
        kind_t              kind;
        logic [LIMIT_W-1:0] wait_count;
        logic [BYTE_W-1:0]  bytes_left;
        logic [FRAME_W-1:0] frame_pos;
        logic [BYTE_W-1:0]  payload_sum;
        logic [ADDR_W-1:0]  dest_addr;
        logic [TOTAL_W-1:0] timeout_total;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:         PH_IDLE,
        kind:          KIND_PLAIN,
        wait_count:    '0,
        bytes_left:    '0,
        frame_pos:     '0,
        payload_sum:   '0,
        dest_addr:     '0,
        timeout_total: '0
    };

endpackage

// ===== rtl/i2c_mts_step.sv =====
// ============================================================================
// i2c_mts_step
// One sequencer step: next transfer state and result item from the current
// state, one request item and the configuration.
// ============================================================================
module i2c_mts_step
    import i2c_mts_pkg::*;
(
    input  cfg_t   cfg,
    input  state_t cur,
    input  req_t   req,
    output state_t nxt,
    output res_t   res
);

    typedef struct packed {
        action_t            action;
        logic [BYTE_W-1:0]  out_byte;
        logic               need_byte;
        phase_t             phase;
        logic [FRAME_W-1:0] frame_pos;
    } tx_step_t;

    // pick what the write side sends next
    function automatic tx_step_t next_tx(
        input kind_t              kind,
        input logic [BYTE_W-1:0]  bytes_left,
        input logic [FRAME_W-1:0] frame_pos,
        input logic [BYTE_W-1:0]  payload_sum,
        input logic [ADDR_W-1:0]  own_address
    );
        tx_step_t           t;
        logic [FRAME_W-1:0] f;
        t.action    = ACT_NONE;
        t.out_byte  = '0;
        t.need_byte = 1'b0;
        t.phase     = PH_TXD;
        t.frame_pos = frame_pos;
        if (kind != KIND_FRAMED) begin
            if (bytes_left != '0) begin
                t.phase     = PH_WANT;
                t.need_byte = 1'b1;
            end
        end else begin
            f = (frame_pos == 3'd2 && bytes_left == '0) ? 3'd3 : frame_pos;
            t.frame_pos = f;
            case (f)
                3'd0:
                begin
                    t.frame_pos = 3'd1;
                    t.action    = ACT_SEND_BYTE;
                    t.out_byte  = {1'b0, own_address};
                    t.phase     = PH_TXING;
                end
                3'd1:
                begin
                    t.frame_pos = (bytes_left != '0) ? 3'd2 : 3'd3;
                    t.action    = ACT_SEND_BYTE;
                    t.out_byte  = bytes_left;
                    t.phase     = PH_TXING;
                end
                3'd2:
                begin
                    t.phase     = PH_WANT;
                    t.need_byte = 1'b1;
                end
                3'd3:
                begin
                    t.frame_pos = 3'd4;
                    t.action    = ACT_SEND_BYTE;
                    t.out_byte  = 8'(~payload_sum + 8'd1);
                    t.phase     = PH_TXING;
                end
                3'd4, 3'd5:
                begin
                    t.frame_pos = 3'(f + 3'd1);
                    t.action    = ACT_SEND_BYTE;
                    t.out_byte  = '0;
                    t.phase     = PH_TXING;
                end
                default:
                begin
                    t.phase = PH_TXD;
                end
            endcase
        end
        return t;
    endfunction

    logic               is_cmd;
    logic               bad_len;
    logic               begin_xfer;
    state_t             eff;
    logic               rd;
    logic               waiting;
    logic               cond;
    logic [LIMIT_W-1:0] limit;
    logic               timed_out;
    tx_step_t           tx;
    logic [BYTE_W-1:0]  bytes_dec;
    logic [BYTE_W-1:0]  sum_add;

    assign is_cmd = (cur.phase == PH_IDLE) &&
                    (req.req_type == REQ_WRITE || req.req_type == REQ_FRAMED ||
                     req.req_type == REQ_READ);
    assign bad_len    = is_cmd && (req.req_type == REQ_FRAMED) &&
                        (req.xfer_length > FRAMED_MAX_LEN);
    assign begin_xfer = is_cmd && !bad_len;

    // state as seen after a command is latched
    always_comb
    begin
        eff = cur;
        if (begin_xfer) begin
            eff.phase       = PH_BUS_PRE;
            eff.wait_count  = '0;
            eff.kind        = (req.req_type == REQ_WRITE)  ? KIND_PLAIN :
                              (req.req_type == REQ_FRAMED) ? KIND_FRAMED : KIND_READ;
            eff.dest_addr   = req.target_addr;
            eff.bytes_left  = req.xfer_length;
            eff.frame_pos   = '0;
            eff.payload_sum = '0;
        end
    end

    assign rd = (eff.kind == KIND_READ);

    // wait condition and limit of the current phase
    always_comb
    begin
        waiting = 1'b1;
        cond    = 1'b0;
        limit   = cfg.short_wait_limit;
        case (eff.phase)
            PH_BUS_PRE, PH_BUS_POST:
            begin
                cond  = !req.bus_busy;
                limit = rd ? cfg.short_wait_limit : cfg.long_wait_limit;
            end
            PH_START: cond = req.start_done;
            PH_ADDR:  cond = req.addr_done;
            PH_TXING: cond = req.byte_transmitting;
            PH_TXD:   cond = req.byte_transmitted;
            PH_RX:    cond = req.byte_received;
            default:  waiting = 1'b0;
        endcase
    end

    assign timed_out = waiting && !cond && (eff.wait_count == limit);

    assign tx = next_tx(eff.kind, eff.bytes_left, eff.frame_pos, eff.payload_sum,
                        cfg.own_address);

    assign bytes_dec = (eff.bytes_left != '0) ? 8'(eff.bytes_left - 8'd1) : '0;
    assign sum_add   = 8'(eff.payload_sum + req.payload_byte);

    always_comb
    begin
        nxt = eff;
        res = '0;
        res.action = ACT_NONE;
        if (timed_out) begin
            nxt.phase         = PH_IDLE;
            nxt.wait_count    = '0;
            nxt.timeout_total = 16'(cur.timeout_total + 16'd1);
            res.failed        = 1'b1;
        end else if (waiting && !cond) begin
            nxt.wait_count = 24'(eff.wait_count + 24'd1);
        end else begin
            case (eff.phase)
                PH_BUS_PRE:
                begin
                    res.action     = ACT_START;
                    nxt.phase      = PH_START;
                    nxt.wait_count = '0;
                end
                PH_START:
                begin
                    res.action     = rd ? ACT_ADDR_READ : ACT_ADDR_WRITE;
                    res.out_byte   = {eff.dest_addr, rd};
                    nxt.phase      = PH_ADDR;
                    nxt.wait_count = '0;
                end
                PH_ADDR, PH_TXING:
                begin
                    nxt.wait_count = '0;
                    if (rd) begin
                        // read side: ack every byte but the last
                        if (eff.bytes_left == '0) begin
                            res.action = ACT_ACK_ON;
                            nxt.phase  = PH_BUS_POST;
                        end else begin
                            res.action = (eff.bytes_left == 8'd1) ? ACT_ACK_OFF_STOP
                                                                  : ACT_ACK_ON;
                            nxt.phase  = PH_RX;
                        end
                    end else begin
                        res.action    = tx.action;
                        res.out_byte  = tx.out_byte;
                        res.need_byte = tx.need_byte;
                        nxt.phase     = tx.phase;
                        nxt.frame_pos = tx.frame_pos;
                    end
                end
                PH_WANT:
                begin
                    if (req.req_type == REQ_PAYLOAD) begin
                        nxt.bytes_left = bytes_dec;
                        if (eff.kind == KIND_FRAMED) begin
                            nxt.payload_sum = sum_add;
                            if (bytes_dec == '0) begin
                                nxt.frame_pos = 3'd3;
                            end
                        end
                        res.action     = ACT_SEND_BYTE;
                        res.out_byte   = req.payload_byte;
                        nxt.phase      = PH_TXING;
                        nxt.wait_count = '0;
                    end else begin
                        res.need_byte = 1'b1;
                    end
                end
                PH_TXD:
                begin
                    res.action     = ACT_STOP;
                    nxt.phase      = PH_BUS_POST;
                    nxt.wait_count = '0;
                end
                PH_RX:
                begin
                    res.read_valid = 1'b1;
                    res.read_byte  = req.rx_data;
                    nxt.bytes_left = bytes_dec;
                    nxt.wait_count = '0;
                    if (bytes_dec == '0) begin
                        res.action = ACT_ACK_ON;
                        nxt.phase  = PH_BUS_POST;
                    end else begin
                        res.action = (bytes_dec == 8'd1) ? ACT_ACK_OFF_STOP : ACT_ACK_ON;
                        nxt.phase  = PH_RX;
                    end
                end
                PH_BUS_POST:
                begin
                    res.action     = ACT_IRQ_ON;
                    res.done_res   = 1'b1;
                    nxt.phase      = PH_IDLE;
                    nxt.wait_count = '0;
                end
                PH_IDLE:
                begin
                    nxt.phase = PH_IDLE;
                end
                default:
                begin
                    nxt.phase      = PH_IDLE;
                    nxt.wait_count = '0;
                end
            endcase
        end
        if (bad_len) begin
            res.failed = 1'b1;
        end
        res.error_total = nxt.timeout_total;
    end

endmodule

// ===== rtl/i2c_master_transfer_sequencer.sv =====
// ============================================================================
// i2c_master_transfer_sequencer
// Sequencer that steps an i2c byte controller through plain writes, framed
// writes and reads, one item per clock unless stalled, bounded status waits.
// ============================================================================
// Each input item (a status tick, a command or a payload byte) yields exactly
// one result item. Items are taken one per clock while the output is not
// stalled: an item sits in the input register while the step logic computes
// the next transfer state and the result, which lands in the result register,
// from where it can be taken at the next edge when the output side is ready.
// The throughput is one item per clock when the output is not stalled, set
// by the single step of state logic between the two registers; a stalled
// output holds the result register and, once the input register is also
// full, stops taking items.
// Configuration writes take effect at the clock edge of the write and are
// meant for times when no transfer is in progress. Each wait but the payload
// byte wait is bounded by a limit register: with a limit of L, failing check
// L+1 fails the transfer and the 16-bit error total counts up.
// ============================================================================
module i2c_master_transfer_sequencer
    import i2c_mts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [LIMIT_W-1:0]    cfg_wdata,

    // request items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // target_addr, xfer_length, payload_byte, bus_busy, start_done,
    // addr_done, byte_transmitting, byte_transmitted, byte_received,
    // rx_data, zero pad
    input  logic [39:0]           s_tdata,
    // req_type
    input  logic [2:0]            s_tuser,

    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // action, out_byte, need_byte, read_valid, read_byte, done_res,
    // failed, error_total
    output logic [39:0]           m_tdata
);

    cfg_t   cfg_reg;
    state_t state_reg;
    state_t state_next;
    req_t   req_reg;
    logic   req_valid_reg;
    res_t   res_reg;
    res_t   res_next;
    logic   res_valid_reg;
    logic   step_fire;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.own_address      <= '0;
            cfg_reg.short_wait_limit <= SHORT_LIMIT_RESET;
            cfg_reg.long_wait_limit  <= LONG_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_OWN_ADDRESS: cfg_reg.own_address      <= cfg_wdata[ADDR_W-1:0];
                CFG_SHORT_LIMIT: cfg_reg.short_wait_limit <= cfg_wdata;
                CFG_LONG_LIMIT:  cfg_reg.long_wait_limit  <= cfg_wdata;
                default:         ; // unused index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake: the step fires when an item is held and the result
    // register is free or being emptied this cycle
    // ------------------------------------------------------------------
    assign step_fire = req_valid_reg && (!res_valid_reg || m_tready);
    assign s_tready  = !req_valid_reg || step_fire;
    assign m_tvalid  = res_valid_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_valid_reg <= 1'b0;
        end else if (s_tready) begin
            req_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid) begin
            req_reg.req_type          <= s_tuser;
            req_reg.target_addr       <= s_tdata[6:0];
            req_reg.xfer_length       <= s_tdata[14:7];
            req_reg.payload_byte      <= s_tdata[22:15];
            req_reg.bus_busy          <= s_tdata[23];
            req_reg.start_done        <= s_tdata[24];
            req_reg.addr_done         <= s_tdata[25];
            req_reg.byte_transmitting <= s_tdata[26];
            req_reg.byte_transmitted  <= s_tdata[27];
            req_reg.byte_received     <= s_tdata[28];
            req_reg.rx_data           <= s_tdata[36:29];
        end
    end

    // ------------------------------------------------------------------
    // step logic
    // ------------------------------------------------------------------
    i2c_mts_step u_step (
        .cfg (cfg_reg),
        .cur (state_reg),
        .req (req_reg),
        .nxt (state_next),
        .res (res_next)
    );

    // transfer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= STATE_RESET;
        end else if (step_fire) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end else if (step_fire) begin
            res_valid_reg <= 1'b1;
        end else if (m_tready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_tdata = {res_reg.error_total, res_reg.failed, res_reg.done_res,
                      res_reg.read_byte, res_reg.read_valid, res_reg.need_byte,
                      res_reg.out_byte, res_reg.action};

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the i2c master transfer sequencer. Request items
// go in over the slave stream and every result item is checked against a
// cycle-free model of the sequencer that is kept in step with the accepted
// items. A short directed part is followed by randomized transfers.
// ----------------------------------------------------------------------------
module tb_top;
    import i2c_mts_pkg::*;

    // framed packet positions
    localparam logic [FRAME_W-1:0] FR_OWN  = 3'd0;
    localparam logic [FRAME_W-1:0] FR_LEN  = 3'd1;
    localparam logic [FRAME_W-1:0] FR_DATA = 3'd2;
    localparam logic [FRAME_W-1:0] FR_SUM  = 3'd3;
    localparam logic [FRAME_W-1:0] FR_PAD0 = 3'd4;
    localparam logic [FRAME_W-1:0] FR_PAD1 = 3'd5;

    localparam logic [LIMIT_W-1:0] LIMIT_MAX = 24'hFFFFFF;
    localparam int unsigned RANDOM_ITEMS = 300;
    localparam int unsigned CALM_FROM    = 220;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LIMIT_W-1:0]   cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [39:0]          s_tdata = '0;
    logic [2:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    logic [39:0]          m_tdata;

    i2c_master_transfer_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // sequencer model: configuration and transfer state
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]  sq_own   = '0;
    logic [LIMIT_W-1:0] sq_short = SHORT_LIMIT_RESET;
    logic [LIMIT_W-1:0] sq_long  = LONG_LIMIT_RESET;
    phase_t             sq_phase = PH_IDLE;
    kind_t              sq_kind  = KIND_PLAIN;
    logic [LIMIT_W-1:0] sq_wait  = '0;
    logic [8:0]         sq_left  = '0;
    logic [FRAME_W-1:0] sq_fpos  = FR_OWN;
    logic [BYTE_W-1:0]  sq_sum   = '0;
    logic [ADDR_W-1:0]  sq_dest  = '0;
    logic [TOTAL_W-1:0] sq_errs  = '0;

    res_t        pending_results[$];
    int unsigned mismatch_count = 0;
    int unsigned items_sent = 0;
    bit          idle_en = 1'b1;
    int unsigned rx_hold = 0;

    // entering a phase restarts its wait counter
    function automatic void go_phase(input phase_t p);
        sq_phase = p;
        sq_wait  = '0;
    endfunction

    // 1 when the awaited condition holds; a timeout aborts to idle
    function automatic bit wait_met(input logic cond, input logic [LIMIT_W-1:0] limit,
                                    inout res_t r);
        if (cond)
            return 1'b1;
        if (sq_wait == limit)
        begin
            sq_errs  = sq_errs + 1'b1;
            r.failed = 1'b1;
            go_phase(PH_IDLE);
        end
        else
        begin
            sq_wait = sq_wait + 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void send_out(inout res_t r, input logic [BYTE_W-1:0] b);
        r.action   = ACT_SEND_BYTE;
        r.out_byte = b;
        go_phase(PH_TXING);
    endfunction

    function automatic void ask_byte(inout res_t r);
        go_phase(PH_WANT);
        r.need_byte = 1'b1;
    endfunction

    // next byte of a write, or on to the transmitted wait
    function automatic void next_tx(inout res_t r);
        if (sq_kind != KIND_FRAMED)
        begin
            if (sq_left != 0)
                ask_byte(r);
            else
                go_phase(PH_TXD);
            return;
        end
        if (sq_fpos == FR_DATA && sq_left == 0)
            sq_fpos = FR_SUM;
        case (sq_fpos)
            FR_OWN:
            begin
                sq_fpos = FR_LEN;
                send_out(r, {1'b0, sq_own});
            end
            FR_LEN:
            begin
                sq_fpos = (sq_left != 0) ? FR_DATA : FR_SUM;
                send_out(r, sq_left[7:0]);
            end
            FR_DATA:
                ask_byte(r);
            FR_SUM:
            begin
                sq_fpos = FR_PAD0;
                send_out(r, ~sq_sum + 8'd1);
            end
            FR_PAD0, FR_PAD1:
            begin
                sq_fpos = sq_fpos + 1'b1;
                send_out(r, 8'h00);
            end
            default:
                go_phase(PH_TXD);
        endcase
    endfunction

    // ack setting for the next read byte; last byte gets ack off plus stop
    function automatic void next_rx(inout res_t r);
        if (sq_left == 0)
        begin
            r.action = ACT_ACK_ON;
            go_phase(PH_BUS_POST);
        end
        else
        begin
            r.action = (sq_left == 1) ? ACT_ACK_OFF_STOP : ACT_ACK_ON;
            go_phase(PH_RX);
        end
    endfunction

    // one accepted request item through the sequencer
    function automatic res_t sequencer_step(input req_t it);
        res_t r;
        logic rd;
        r = '0;
        r.action = ACT_NONE;
        if (sq_phase == PH_IDLE && it.req_type >= REQ_WRITE && it.req_type <= REQ_READ)
        begin
            if (it.req_type == REQ_FRAMED && it.xfer_length > FRAMED_MAX_LEN)
            begin
                // oversize framed request: fails without counting an error
                r.failed = 1'b1;
            end
            else
            begin
                sq_kind = (it.req_type == REQ_WRITE)  ? KIND_PLAIN :
                          (it.req_type == REQ_FRAMED) ? KIND_FRAMED : KIND_READ;
                sq_dest = it.target_addr;
                sq_left = {1'b0, it.xfer_length};
                sq_fpos = FR_OWN;
                sq_sum  = '0;
                go_phase(PH_BUS_PRE);
            end
        end
        rd = (sq_kind == KIND_READ);

        case (sq_phase)
            PH_BUS_PRE:
                if (wait_met(!it.bus_busy, rd ? sq_short : sq_long, r))
                begin
                    r.action = ACT_START;
                    go_phase(PH_START);
                end
            PH_START:
                if (wait_met(it.start_done, sq_short, r))
                begin
                    r.action   = rd ? ACT_ADDR_READ : ACT_ADDR_WRITE;
                    r.out_byte = {sq_dest, rd};
                    go_phase(PH_ADDR);
                end
            PH_ADDR:
                if (wait_met(it.addr_done, sq_short, r))
                begin
                    if (rd)
                        next_rx(r);
                    else
                        next_tx(r);
                end
            PH_WANT:
                // no timeout while a payload byte is awaited
                if (it.req_type == REQ_PAYLOAD)
                begin
                    if (sq_left != 0)
                        sq_left = sq_left - 1'b1;
                    if (sq_kind == KIND_FRAMED)
                    begin
                        sq_sum = sq_sum + it.payload_byte;
                        if (sq_left == 0)
                            sq_fpos = FR_SUM;
                    end
                    send_out(r, it.payload_byte);
                end
                else
                begin
                    r.need_byte = 1'b1;
                end
            PH_TXING:
                if (wait_met(it.byte_transmitting, sq_short, r))
                    next_tx(r);
            PH_TXD:
                if (wait_met(it.byte_transmitted, sq_short, r))
                begin
                    r.action = ACT_STOP;
                    go_phase(PH_BUS_POST);
                end
            PH_RX:
                if (wait_met(it.byte_received, sq_short, r))
                begin
                    r.read_valid = 1'b1;
                    r.read_byte  = it.rx_data;
                    if (sq_left != 0)
                        sq_left = sq_left - 1'b1;
                    next_rx(r);
                end
            PH_BUS_POST:
                if (wait_met(!it.bus_busy, rd ? sq_short : sq_long, r))
                begin
                    r.action   = ACT_IRQ_ON;
                    r.done_res = 1'b1;
                    go_phase(PH_IDLE);
                end
            default:
                ;
        endcase
        r.error_total = sq_errs;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stream packing
    // ------------------------------------------------------------------
    function automatic logic [39:0] pack_request(input req_t it);
        return {3'b000, it.rx_data, it.byte_received, it.byte_transmitted,
                it.byte_transmitting, it.addr_done, it.start_done, it.bus_busy,
                it.payload_byte, it.xfer_length, it.target_addr};
    endfunction

    function automatic res_t unpack_result(input logic [39:0] d);
        res_t r;
        r.action      = action_t'(d[3:0]);
        r.out_byte    = d[11:4];
        r.need_byte   = d[12];
        r.read_valid  = d[13];
        r.read_byte   = d[21:14];
        r.done_res    = d[22];
        r.failed      = d[23];
        r.error_total = d[39:24];
        return r;
    endfunction

    function automatic string result_text(input res_t r);
        return $sformatf("act=%0d byte=%02h need=%b rv=%b rb=%02h done=%b fail=%b err=%0d",
                         r.action, r.out_byte, r.need_byte, r.read_valid, r.read_byte,
                         r.done_res, r.failed, r.error_total);
    endfunction

    // ------------------------------------------------------------------
    // result side: random back-pressure and checking
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rx_hold > 0)
            rx_hold <= rx_hold - 1;
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            rx_hold  <= $urandom_range(0, 8);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = unpack_result(m_tdata);
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result item with none expected: %s", $realtime,
                             result_text(got));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.action !== want.action || got.out_byte !== want.out_byte ||
                    got.need_byte !== want.need_byte || got.read_valid !== want.read_valid ||
                    got.read_byte !== want.read_byte || got.done_res !== want.done_res ||
                    got.failed !== want.failed || got.error_total !== want.error_total)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
                                 result_text(want), result_text(got));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    // valid stays high between back-to-back items; predicted at acceptance
    task automatic send_item(input req_t it);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_request(it);
        s_tuser  <= it.req_type;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(sequencer_step(it));
        items_sent++;
    endtask

    // stop sending and wait until every expected result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // all three registers, back to back; only with the pipeline empty
    task automatic set_config(input logic [ADDR_W-1:0] own, input logic [LIMIT_W-1:0] s_lim,
                              input logic [LIMIT_W-1:0] l_lim);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_OWN_ADDRESS;
        cfg_wdata <= {{(LIMIT_W-ADDR_W){1'b0}}, own};
        @(posedge clk);
        cfg_index <= CFG_SHORT_LIMIT;
        cfg_wdata <= s_lim;
        @(posedge clk);
        cfg_index <= CFG_LONG_LIMIT;
        cfg_wdata <= l_lim;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sq_own   = own;
        sq_short = s_lim;
        sq_long  = l_lim;
    endtask

    function automatic req_t random_item();
        req_t it;
        it.req_type          = 3'($urandom_range(0, 7));
        it.target_addr       = 7'($urandom);
        it.xfer_length       = 8'($urandom);
        it.payload_byte      = 8'($urandom);
        it.bus_busy          = 1'($urandom);
        it.start_done        = 1'($urandom);
        it.addr_done         = 1'($urandom);
        it.byte_transmitting = 1'($urandom);
        it.byte_transmitted  = 1'($urandom);
        it.byte_received     = 1'($urandom);
        it.rx_data           = 8'($urandom);
        return it;
    endfunction

    // status item for the current phase; the awaited event is present
    // with probability ok_pct, otherwise the status bits are random
    function automatic req_t status_item(input int unsigned ok_pct);
        req_t it;
        bit   ok;
        it = random_item();
        ok = ($urandom_range(1, 100) <= ok_pct);
        it.req_type = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : REQ_TICK;
        case (sq_phase)
            PH_BUS_PRE, PH_BUS_POST: if (ok) it.bus_busy = 1'b0;
            PH_START:                if (ok) it.start_done = 1'b1;
            PH_ADDR:                 if (ok) it.addr_done = 1'b1;
            PH_TXING:                if (ok) it.byte_transmitting = 1'b1;
            PH_TXD:                  if (ok) it.byte_transmitted = 1'b1;
            PH_RX:                   if (ok) it.byte_received = 1'b1;
            PH_WANT:                 it.req_type = ok ? REQ_PAYLOAD : REQ_TICK;
            default:                 ;
        endcase
        return it;
    endfunction

    task automatic advance_to_idle(input int unsigned ok_pct);
        while (sq_phase != PH_IDLE)
            send_item(status_item(ok_pct));
    endtask

    task automatic run_transfer(input req_code_t code, input logic [ADDR_W-1:0] addr,
                                input logic [BYTE_W-1:0] len, input int unsigned ok_pct);
        req_t it;
        it = random_item();
        it.req_type    = code;
        it.target_addr = addr;
        it.xfer_length = len;
        if ($urandom_range(1, 100) <= ok_pct)
            it.bus_busy = 1'b0;
        send_item(it);
        advance_to_idle(ok_pct);
    endtask

    function automatic logic [LIMIT_W-1:0] pick_limit();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        if (r < 25)
            return LIMIT_MAX;
        if (r < 35)
            return 24'($urandom);
        return 24'($urandom_range(1, 12));
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_framed_length_limit();
        req_t it;
        it = random_item();
        it.req_type    = REQ_FRAMED;
        it.xfer_length = FRAMED_MAX_LEN + 8'd1;
        send_item(it);
        it = random_item();
        it.req_type    = REQ_FRAMED;
        it.xfer_length = 8'hFF;
        send_item(it);
    endtask

    // payload bytes and unused request codes do nothing while idle
    task automatic test_idle_ignores();
        req_t it;
        int   code;
        for (code = REQ_PAYLOAD; code <= 7; code++)
        begin
            it = random_item();
            it.req_type = 3'(code);
            send_item(it);
        end
        it = random_item();
        it.req_type = REQ_TICK;
        send_item(it);
    endtask

    task automatic test_short_transfers();
        run_transfer(REQ_WRITE, 7'h7F, 8'd0, 100);
        run_transfer(REQ_READ, 7'h00, 8'd0, 100);
        run_transfer(REQ_READ, 7'h7F, 8'd1, 100);
        run_transfer(REQ_FRAMED, 7'h2A, 8'd0, 100);
        run_transfer(REQ_FRAMED, 7'h55, 8'd2, 100);
    endtask

    // a command arriving mid-transfer is just a status tick
    task automatic test_command_while_busy();
        req_t it;
        run_transfer(REQ_WRITE, 7'h11, 8'd2, 100);
        run_transfer(REQ_READ, 7'h12, 8'd2, 100);
        it = random_item();
        it.req_type    = REQ_WRITE;
        it.xfer_length = 8'd1;
        it.bus_busy    = 1'b0;
        send_item(it);
        it = status_item(100);
        it.req_type = REQ_READ;
        send_item(it);
        it = status_item(100);
        it.req_type = REQ_FRAMED;
        send_item(it);
        advance_to_idle(100);
    endtask

    // read with the bus held busy until the short limit runs out
    task automatic test_wait_timeout();
        req_t it;
        it = random_item();
        it.req_type    = REQ_READ;
        it.xfer_length = 8'd2;
        it.bus_busy    = 1'b1;
        send_item(it);
        while (sq_phase != PH_IDLE)
        begin
            it = random_item();
            it.req_type = REQ_TICK;
            it.bus_busy = 1'b1;
            send_item(it);
        end
    endtask

    task automatic test_limit_extremes();
        settle();
        set_config(7'h00, LIMIT_MAX, LIMIT_MAX);
        run_transfer(REQ_FRAMED, 7'h01, 8'd3, 50);
        run_transfer(REQ_READ, 7'h7E, 8'd3, 50);
        run_transfer(REQ_WRITE, 7'h40, 8'd2, 50);
        settle();
        set_config(7'h7F, '0, '0);
        run_transfer(REQ_FRAMED, 7'h03, 8'd2, 85);
        run_transfer(REQ_READ, 7'h04, 8'd4, 85);
        run_transfer(REQ_WRITE, 7'h05, 8'd3, 85);
        // longest payloads
        run_transfer(REQ_FRAMED, 7'($urandom), FRAMED_MAX_LEN, 100);
        run_transfer(REQ_WRITE, 7'($urandom), 8'hFF, 100);
        run_transfer(REQ_READ, 7'($urandom), 8'hFF, 100);
    endtask

    task automatic test_random_traffic();
        int unsigned counted;
        int unsigned phase_items;
        int unsigned base;
        int unsigned n;
        int unsigned ok_pct;
        req_code_t   code;
        logic [7:0]  len;
        counted     = 0;
        phase_items = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (phase_items >= 100)
            begin
                advance_to_idle(100);
                settle();
                set_config(7'($urandom), pick_limit(), pick_limit());
                phase_items = 0;
            end
            idle_en = (counted < CALM_FROM);
            base = items_sent;
            if ($urandom_range(0, 6) == 0)
            begin
                // noise: arbitrary items, possibly starting or breaking transfers
                for (n = $urandom_range(1, 4); n > 0; n--)
                    send_item(random_item());
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       code = REQ_WRITE;
                    1:       code = REQ_FRAMED;
                    default: code = REQ_READ;
                endcase
                if ($urandom_range(0, 99) < 1)
                    len = 8'($urandom_range(200, 255));
                else
                    len = 8'($urandom_range(0, 6));
                ok_pct = ($urandom_range(0, 1) == 0) ? 100 : $urandom_range(50, 95);
                run_transfer(code, 7'($urandom), len, ok_pct);
            end
            counted     += items_sent - base;
            phase_items += items_sent - base;
        end
    endtask

    // ------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_config(7'h7F, 24'd2, 24'd3);
        test_framed_length_limit();
        test_idle_ignores();
        test_short_transfers();
        test_command_while_busy();
        test_wait_timeout();
        test_limit_extremes();
        test_random_traffic();
        settle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/i2c_mts_pkg.sv
rtl/i2c_mts_step.sv
rtl/i2c_master_transfer_sequencer.sv
tb/sv/tb_top.sv
